// ----- rtl/core/wbps_pkg.sv -----
// Shared constants for the wildcard byte pattern search block.
package wbps_pkg;

	// Default sizing of the search
	localparam int MAX_PATTERN_BYTES_DEF = 8;
	localparam int OFFSET_BITS_DEF       = 24;

	// Configuration port geometry: 64-bit registers at byte address 8*i
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_SEL_LO = 3;

	// Register indexes (paddr[4:3])
	localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
	localparam logic [1:0] REG_PATTERN_CARE   = 2'd1;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

	// Fixed widths of the pattern registers and stream fields
	localparam int PAT_BYTES_W = 64;
	localparam int PAT_CARE_W  = 8;
	localparam int PAT_LEN_W   = 4;
	localparam int CODE_W      = 8;

endpackage

// ----- rtl/core/wildcard_byte_pattern_search.sv -----
// Top level of the wildcard byte pattern search: window, compare and result queue.
//
// Code bytes arrive on the s_ stream, one byte per item, with s_tlast on the final
// byte of a search. The pattern (up to MAX_PATTERN_BYTES bytes, each required or
// wildcard) is to be written through the APB port while the block is idle; the block
// does not enforce this. Pattern bytes at 0x00, care mask at 0x08, length at 0x10.
// Each search gives at most one result on the m_ stream: m_tuser high with the start
// offset of the first match in m_tdata, or m_tuser low with a zero offset when the
// final byte arrives without a match. Bytes after a match are consumed silently.
// Throughput: one byte per cycle while s_tready is high; the masked window compare
// and the offset arithmetic are combinational between the search state and the
// result register.
// A result register and a skid register sit on the output, so bytes keep being
// accepted while one result waits; s_tready drops only while both hold a result,
// and rises again once the receiver takes one.
// Reset clears the search state, the pattern registers and both result valid flags.
module wildcard_byte_pattern_search #(
	parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int OFFSET_BITS       = wbps_pkg::OFFSET_BITS_DEF,
	localparam int OUT_DATA_W       = ((OFFSET_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Code byte stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wbps_pkg::CODE_W-1:0]     s_tdata,   // [7:0] code_byte
	input  logic                            s_tlast,   // end_of_code
	// Result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [OUT_DATA_W-1:0]           m_tdata,   // [OFFSET_BITS-1:0] match_offset, zero pad
	output logic                            m_tuser,   // [0] match_found
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wbps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [wbps_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int SEEN_W = OFFSET_BITS + 1;
	localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	// Pattern registers
	logic [wbps_pkg::PAT_BYTES_W-1:0] pattern_bytes_q;
	logic [wbps_pkg::PAT_CARE_W-1:0]  pattern_care_q;
	logic [wbps_pkg::PAT_LEN_W-1:0]   pattern_length_q;

	// Search state
	logic [wbps_pkg::CODE_W-1:0] window_q [MAX_PATTERN_BYTES];
	logic [SEEN_W-1:0]           seen_q;
	logic                        done_q;

	// Output queue: result register and skid register
	logic                   out_valid_q;
	logic                   out_found_q;
	logic [OFFSET_BITS-1:0] out_offset_q;
	logic                   skid_valid_q;
	logic                   skid_found_q;
	logic [OFFSET_BITS-1:0] skid_offset_q;

	// Datapath signals
	logic [wbps_pkg::CODE_W-1:0] new_window [MAX_PATTERN_BYTES];
	logic [SEEN_W-1:0]           new_seen;
	logic [SEEN_W-1:0]           start_off;
	logic [OFFSET_BITS-1:0]      start_off_sat;
	logic [LEN_W-1:0]            len_used;
	logic [IDX_W-1:0]            win_idx;
	logic                        bytes_hit;
	logic                        match;
	logic                        s_accept;
	logic                        m_pop;
	logic                        push;
	logic                        push_found;
	logic [OFFSET_BITS-1:0]      push_offset;
	logic                        cfg_write;
	logic [1:0]                  cfg_sel;

	assign pready    = 1'b1;
	assign cfg_sel   = paddr[wbps_pkg::CFG_ADDR_W-1:wbps_pkg::CFG_SEL_LO];
	assign cfg_write = psel && penable && pwrite && pready;

	// Write the pattern registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q  <= '0;
			pattern_care_q   <= '0;
			pattern_length_q <= '0;
		end else if (cfg_write) begin
			case (cfg_sel)
				wbps_pkg::REG_PATTERN_BYTES:  pattern_bytes_q  <= pwdata;
				wbps_pkg::REG_PATTERN_CARE:   pattern_care_q   <= pwdata[wbps_pkg::PAT_CARE_W-1:0];
				wbps_pkg::REG_PATTERN_LENGTH: pattern_length_q <= pwdata[wbps_pkg::PAT_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the pattern registers
	always_comb begin
		case (cfg_sel)
			wbps_pkg::REG_PATTERN_BYTES:  prdata = pattern_bytes_q;
			wbps_pkg::REG_PATTERN_CARE:   prdata = wbps_pkg::CFG_DATA_W'(pattern_care_q);
			wbps_pkg::REG_PATTERN_LENGTH: prdata = wbps_pkg::CFG_DATA_W'(pattern_length_q);
			default:                      prdata = '0;
		endcase
	end

	// Clamp the pattern length to the window depth
	always_comb begin
		if (pattern_length_q > wbps_pkg::PAT_LEN_W'(MAX_PATTERN_BYTES))
			len_used = LEN_W'(MAX_PATTERN_BYTES);
		else
			len_used = LEN_W'(pattern_length_q);
	end

	// Shift the new byte into the window, newest at entry 0
	always_comb begin
		new_window[0] = s_tdata;
		for (int j = 1; j < MAX_PATTERN_BYTES; j++)
			new_window[j] = window_q[j-1];
	end

	// Count bytes, holding at all ones
	assign new_seen = (seen_q != '1) ? seen_q + SEEN_W'(1) : seen_q;

	// Compare the cared pattern bytes against the window, oldest byte first
	always_comb begin
		bytes_hit = 1'b1;
		win_idx   = '0;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			if (LEN_W'(k) < len_used) begin
				win_idx = IDX_W'(len_used - LEN_W'(k) - LEN_W'(1));
				if (pattern_care_q[k] && (pattern_bytes_q[8*k +: 8] != new_window[win_idx]))
					bytes_hit = 1'b0;
			end
		end
	end

	assign match = (len_used != '0) && (new_seen >= SEEN_W'(len_used)) && bytes_hit;

	// Start offset, saturated to the offset width
	assign start_off     = new_seen - SEEN_W'(len_used);
	assign start_off_sat = start_off[SEEN_W-1] ? '1 : start_off[OFFSET_BITS-1:0];

	// Handshakes and the result of this byte
	assign s_tready    = !skid_valid_q;
	assign s_accept    = s_tvalid && s_tready;
	assign m_pop       = m_tvalid && m_tready;
	assign push        = s_accept && !done_q && (match || s_tlast);
	assign push_found  = match;
	assign push_offset = match ? start_off_sat : '0;

	// Advance the search state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PATTERN_BYTES; j++)
				window_q[j] <= '0;
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (s_accept) begin
			if (s_tlast) begin
				for (int j = 0; j < MAX_PATTERN_BYTES; j++)
					window_q[j] <= '0;
				seen_q <= '0;
				done_q <= 1'b0;
			end else if (!done_q) begin
				for (int j = 0; j < MAX_PATTERN_BYTES; j++)
					window_q[j] <= new_window[j];
				seen_q <= new_seen;
				done_q <= match;
			end
		end
	end

	// Result register with skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || m_pop) begin
			if (skid_valid_q) begin
				out_found_q  <= skid_found_q;
				out_offset_q <= skid_offset_q;
			end else if (push) begin
				out_found_q  <= push_found;
				out_offset_q <= push_offset;
			end
		end else if (push) begin
			skid_found_q  <= push_found;
			skid_offset_q <= push_offset;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = OUT_DATA_W'(out_offset_q);

	// A held skid result always has a result in front of it
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the result register is empty");

	// No result once the search has already matched
	a_silent_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && done_q) |-> !push)
		else $error("result pushed after a match was reported");

	// The final byte clears the search
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_tlast) |=> (seen_q == '0 && !done_q))
		else $error("search state not cleared after the final byte");

	// A not-found result carries a zero offset
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("not-found result with a nonzero offset");

	// A push while both result slots are full would lose a result
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_pop && push) |-> !skid_valid_q)
		else $error("result pushed into a full output queue");

endmodule

// ----- tb/sv/wildcard_byte_pattern_search_checker.sv -----
`timescale 1ns / 1ps
// Checker for the wildcard byte pattern search: tracks the pattern, predicts and compares results.
module wildcard_byte_pattern_search_checker #(
	parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int OFFSET_BITS       = wbps_pkg::OFFSET_BITS_DEF,
	localparam int OUT_DATA_W       = ((OFFSET_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [wbps_pkg::CODE_W-1:0]     s_tdata,   // [7:0] code_byte
	input  logic                            s_tlast,   // end_of_code
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [OUT_DATA_W-1:0]           m_tdata,   // [OFFSET_BITS-1:0] match_offset, zero pad
	input  logic                            m_tuser,   // [0] match_found
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wbps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] pwdata,
	input  logic                            pready,
	output int                              fail_count,
	output int                              pending
);

	localparam logic [OFFSET_BITS:0]   SEEN_MAX   = '1;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	typedef struct packed {
		logic                  found;
		logic [OUT_DATA_W-1:0] offset;
	} search_result_t;

	// Pattern registers as last written
	logic [wbps_pkg::PAT_BYTES_W-1:0] pat_bytes;
	logic [wbps_pkg::PAT_CARE_W-1:0]  pat_care;
	logic [wbps_pkg::PAT_LEN_W-1:0]   pat_len;

	// Search state of the block
	logic [7:0]           window [MAX_PATTERN_BYTES];
	logic [OFFSET_BITS:0] seen;
	logic                 matched;

	search_result_t search_result_q [$];
	search_result_t want;
	search_result_t got;
	int             errors;
	bit             has_result;

	function automatic void clear_search();
		for (int k = 0; k < MAX_PATTERN_BYTES; k++)
			window[k] = '0;
		seen    = '0;
		matched = 1'b0;
	endfunction

	// Advance the search by one code byte; flag a result where one is due
	function automatic void scan_code_byte(input logic [7:0] b, input logic last,
			output bit has_res, output search_result_t res);
		int                   used;
		bit                   hit;
		logic [OFFSET_BITS:0] span;
		used    = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len);
		has_res = 1'b0;
		res     = '0;
		if (!matched) begin
			for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--)
				window[k] = window[k - 1];
			window[0] = b;
			if (seen < SEEN_MAX)
				seen = seen + 1'b1;
			hit = (used > 0) && (seen >= used);
			for (int k = 0; k < used; k++) begin
				if (pat_care[k] && pat_bytes[8 * k +: 8] != window[used - 1 - k])
					hit = 1'b0;
			end
			if (hit) begin
				span = seen - (OFFSET_BITS + 1)'(used);
				if (span > OFFSET_MAX)
					span = OFFSET_MAX;
				res.found  = 1'b1;
				res.offset = OUT_DATA_W'(span[OFFSET_BITS-1:0]);
				matched    = 1'b1;
				has_res    = 1'b1;
			end else if (last) begin
				has_res = 1'b1;
			end
		end
		if (last)
			clear_search();
	endfunction

	// Compare results first, then take register writes and predict new items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_search();
			pat_bytes = '0;
			pat_care  = '0;
			pat_len   = '0;
			search_result_q.delete();
			errors = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.found  = m_tuser;
				got.offset = m_tdata;
				if (search_result_q.size() == 0) begin
					$error("unexpected result: match_found %0d, match_offset %0d",
						got.found, got.offset);
					errors++;
				end else begin
					want = search_result_q.pop_front();
					if (got.found !== want.found) begin
						$error("match_found: expected %0d, actual %0d", want.found, got.found);
						errors++;
					end
					if (got.offset !== want.offset) begin
						$error("match_offset: expected %0d, actual %0d",
							want.offset, got.offset);
						errors++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[wbps_pkg::CFG_ADDR_W-1:wbps_pkg::CFG_SEL_LO])
					wbps_pkg::REG_PATTERN_BYTES:
						pat_bytes = pwdata[wbps_pkg::PAT_BYTES_W-1:0];
					wbps_pkg::REG_PATTERN_CARE:
						pat_care  = pwdata[wbps_pkg::PAT_CARE_W-1:0];
					wbps_pkg::REG_PATTERN_LENGTH:
						pat_len   = pwdata[wbps_pkg::PAT_LEN_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				scan_code_byte(s_tdata, s_tlast, has_result, want);
				if (has_result)
					search_result_q.push_back(want);
			end
			pending    <= search_result_q.size();
			fail_count <= errors;
		end
	end

endmodule

// ----- tb/sv/wildcard_byte_pattern_search_tb.sv -----
`timescale 1ns / 1ps
// Top of the wildcard byte pattern search testbench: clock, reset, stimulus and verdict.
module wildcard_byte_pattern_search_tb;

	localparam int OUT_DATA_W  = ((wbps_pkg::OFFSET_BITS_DEF + 7) / 8) * 8;
	localparam int ITEM_TARGET = 1250;
	localparam int CYCLE_LIMIT = 400000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [wbps_pkg::CODE_W-1:0]     s_tdata  = '0;
	logic                            s_tlast  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]           m_tdata;
	logic                            m_tuser;
	logic                            psel     = 1'b0;
	logic                            penable  = 1'b0;
	logic                            pwrite   = 1'b0;
	logic [wbps_pkg::CFG_ADDR_W-1:0] paddr    = '0;
	logic [wbps_pkg::CFG_DATA_W-1:0] pwdata   = '0;
	logic [wbps_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;

	int fail_count;
	int pending;
	int cycles     = 0;
	int items_sent = 0;
	int burst_left = 0;
	int ready_left = 0;

	// Pattern as programmed, used to plant matches in the code
	logic [wbps_pkg::PAT_BYTES_W-1:0] cur_bytes = '0;
	logic [wbps_pkg::PAT_CARE_W-1:0]  cur_care  = '0;
	logic [wbps_pkg::PAT_LEN_W-1:0]   cur_len   = '0;

	wildcard_byte_pattern_search u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	wildcard_byte_pattern_search_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("wildcard_byte_pattern_search_tb: FAIL");
			$finish;
		end
	end

	// Receiver: alternate ready and stall runs, with the odd long ready stretch
	always @(posedge clk) begin
		if (ready_left == 0) begin
			if (!m_tready)
				ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 12);
			else
				ready_left = $urandom_range(1, 8);
			m_tready <= ~m_tready;
		end else begin
			ready_left--;
		end
	end

	// Offer one code byte, with a random gap at the start of each burst
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Hold off until every result is in, then let the pipeline settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx,
			input logic [wbps_pkg::CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Program all three registers; junk in the unused upper bits
	task automatic set_pattern(input logic [63:0] pb, input logic [7:0] care,
			input logic [3:0] len);
		cur_bytes = pb;
		cur_care  = care;
		cur_len   = len;
		cfg_write(wbps_pkg::REG_PATTERN_BYTES, pb);
		cfg_write(wbps_pkg::REG_PATTERN_CARE,
			{$urandom, 24'($urandom_range(0, 16777215)), care});
		cfg_write(wbps_pkg::REG_PATTERN_LENGTH,
			{$urandom, 28'($urandom_range(0, 268435455)), len});
	endtask

	// Send one search; optionally plant the pattern, optionally spoil it
	task automatic run_search(input int n, input bit plant, input bit spoil, input bit narrow);
		logic [7:0] code_buf [0:511];
		int         used;
		int         pos;
		int         k;
		used = (cur_len > wbps_pkg::MAX_PATTERN_BYTES_DEF) ? wbps_pkg::MAX_PATTERN_BYTES_DEF
			: int'(cur_len);
		for (int i = 0; i < n; i++) begin
			if (!narrow)
				code_buf[i] = 8'($urandom_range(0, 255));
			else
				case ($urandom_range(0, 3))
					0:       code_buf[i] = 8'h00;
					1:       code_buf[i] = 8'hFF;
					default: code_buf[i] = cur_bytes[8 * $urandom_range(0, 7) +: 8];
				endcase
		end
		if (plant && used > 0 && n >= used) begin
			pos = $urandom_range(0, n - used);
			for (k = 0; k < used; k++)
				if (cur_care[k])
					code_buf[pos + k] = cur_bytes[8 * k +: 8];
			if (spoil) begin
				k = $urandom_range(0, used - 1);
				code_buf[pos + k] = code_buf[pos + k] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		for (int i = 0; i < n; i++)
			send_byte(code_buf[i], i == n - 1);
	endtask

	initial begin
		int         nsearch;
		int         n;
		int         mode;
		logic [3:0] len;
		logic [7:0] care;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pattern straight after reset
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain_results();

		// Three-byte pattern with a wildcard in the middle
		set_pattern(64'h0000_0000_00CD_00AB, 8'b0000_0101, 4'd3);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hCD, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h66, 1'b1);
		// Code shorter than the pattern
		send_byte(8'hAB, 1'b0);
		send_byte(8'h00, 1'b1);
		// Match on the final byte
		send_byte(8'hAB, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hCD, 1'b1);
		drain_results();

		// Length above the maximum, all wildcards
		set_pattern(64'hFF00_FF00_FF00_FF00, 8'h00, 4'd15);
		for (int i = 0; i < 8; i++)
			send_byte((i % 2) ? 8'hFF : 8'h00, i == 7);
		drain_results();

		// Care bits beyond the length, first byte a wildcard
		set_pattern(64'hFFFF_FFFF_FFFF_FFFF, 8'hFE, 4'd1);
		send_byte(8'h3C, 1'b1);
		drain_results();

		// Random phases, each with its own pattern
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0:                         len = 4'd0;
				1, 2, 3, 4, 5, 6, 7, 8,
				9, 10, 11, 12:             len = 4'($urandom_range(1, 4));
				13, 14, 15:                len = 4'($urandom_range(5, 8));
				16, 17:                    len = 4'd8;
				default:                   len = 4'($urandom_range(9, 15));
			endcase
			case ($urandom_range(0, 7))
				0:       care = 8'h00;
				1, 2:    care = 8'hFF;
				default: care = 8'($urandom_range(0, 255));
			endcase
			set_pattern({$urandom, $urandom}, care, len);
			nsearch = $urandom_range(1, 6);
			for (int s = 0; s < nsearch; s++) begin
				case ($urandom_range(0, 15))
					0:       n = $urandom_range(1, 3);
					15:      n = $urandom_range(100, 400);
					default: n = $urandom_range(1, 40);
				endcase
				mode = $urandom_range(0, 7);
				run_search(n, mode < 6, mode == 5, 1'($urandom_range(0, 1)));
			end
			drain_results();
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("wildcard_byte_pattern_search_tb: PASS");
		else
			$display("wildcard_byte_pattern_search_tb: FAIL");
		$finish;
	end

endmodule
